[sv/sfc_pkg.sv]
`timescale 1ns / 1ps

package sfc_pkg;

    // field and datapath widths
    localparam int COEF_W     = 32;
    localparam int COORD_W    = 32;
    localparam int PROD_W     = COEF_W + COORD_W;
    localparam int COEF_FRAC  = 24;
    localparam int TRANS_SH   = 8;
    localparam int CLIP_W     = 42;
    localparam int NDC_FRAC   = 16;
    localparam int NDC_W      = 31;
    localparam int DIV_STEPS  = NDC_W;
    localparam int REM_W      = 74;
    localparam int DIV_LAT    = DIV_STEPS + 3;
    localparam int SQ_W       = 2 * NDC_W;
    localparam int ROOT_W     = 32;
    localparam int SRT_W      = 2 * ROOT_W;
    localparam int TEST_W     = ROOT_W + 3;

    // ports
    localparam int NUM_PTS    = 2;
    localparam int NUM_ROWS   = 4;
    localparam int NUM_AXES   = 3;
    localparam int IN_W       = NUM_PTS * NUM_AXES * COORD_W;
    localparam int OUT_W      = 8;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 2 * COEF_W;
    localparam int NUM_CFG    = 8;

    // plane constant, 1.0 in Q.16
    localparam int NDC_ONE    = 65536;

    // queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    // output bit positions
    localparam int OUT_IN_VIEW    = 0;
    localparam int OUT_DEGENERATE = 1;

    typedef logic signed [CLIP_W-1:0] clip_t;

    // one classified sphere: clip coordinates of both points and the zero-w flag
    typedef struct packed {
        logic                                  wz;
        logic [NUM_PTS-1:0][NUM_ROWS-1:0][CLIP_W-1:0] clip;
    } item_t;

endpackage

[sv/sfc_fifo.sv]
`timescale 1ns / 1ps

module sfc_fifo
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  sfc_pkg::item_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           out_valid,
    output sfc_pkg::item_t out_data
);
    import sfc_pkg::*;

    item_t                mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [FIFO_AW:0]     count_reg;
    logic [FIFO_AW:0]     count_next;

    assign full      = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> out_valid)
        else $error("queue read while empty");

endmodule

[sv/sfc_front.sv]
`timescale 1ns / 1ps

module sfc_front
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [sfc_pkg::IN_W-1:0]         in_data,
    input  logic                             cfg_valid,
    input  logic [sfc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sfc_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             q_full,
    output logic                             push,
    output sfc_pkg::item_t                   push_data
);
    import sfc_pkg::*;

    logic signed [COEF_W-1:0]  coef_reg [NUM_ROWS][NUM_ROWS];
    logic signed [COORD_W-1:0] coord [NUM_PTS][NUM_AXES];
    logic signed [PROD_W-1:0]  prod_reg [NUM_PTS][NUM_ROWS][NUM_AXES];
    logic                      v1_reg;
    logic                      v2_reg;
    item_t                     item_reg;
    item_t                     item_next;
    logic                      en;
    logic [1:0]                cfg_row;
    logic [1:0]                cfg_col_lo;
    logic [1:0]                cfg_col_hi;

    assign en        = !q_full;
    assign in_ready  = en;
    assign push      = v2_reg && en;
    assign push_data = item_reg;

    assign cfg_row    = cfg_index[2:1];
    assign cfg_col_lo = {cfg_index[0], 1'b0};
    assign cfg_col_hi = {cfg_index[0], 1'b1};

    // matrix coefficients, lower column in the low word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < NUM_ROWS; r++)
            begin
                for (int c = 0; c < NUM_ROWS; c++)
                begin
                    coef_reg[r][c] <= '0;
                end
            end
        end
        else if (cfg_valid && (cfg_index < CFG_IDX_W'(NUM_CFG)))
        begin
            coef_reg[cfg_row][cfg_col_lo] <= cfg_data[COEF_W-1:0];
            coef_reg[cfg_row][cfg_col_hi] <= cfg_data[CFG_DATA_W-1:COEF_W];
        end
    end

    // unpack world coordinates
    always_comb
    begin
        for (int p = 0; p < NUM_PTS; p++)
        begin
            for (int a = 0; a < NUM_AXES; a++)
            begin
                coord[p][a] = in_data[(p*NUM_AXES+a)*COORD_W +: COORD_W];
            end
        end
    end

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    // stage one: all matrix products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int p = 0; p < NUM_PTS; p++)
            begin
                for (int r = 0; r < NUM_ROWS; r++)
                begin
                    for (int a = 0; a < NUM_AXES; a++)
                    begin
                        prod_reg[p][r][a] <= coef_reg[r][a] * coord[p][a];
                    end
                end
            end
        end
    end

    // stage two: row sums with translation, zero-w check
    always_comb
    begin
        for (int p = 0; p < NUM_PTS; p++)
        begin
            for (int r = 0; r < NUM_ROWS; r++)
            begin
                item_next.clip[p][r] = CLIP_W'(prod_reg[p][r][0] >>> COEF_FRAC)
                                     + CLIP_W'(prod_reg[p][r][1] >>> COEF_FRAC)
                                     + CLIP_W'(prod_reg[p][r][2] >>> COEF_FRAC)
                                     + CLIP_W'(coef_reg[r][3] >>> TRANS_SH);
            end
        end
        item_next.wz = (item_next.clip[0][3] == '0) || (item_next.clip[1][3] == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg <= item_next;
        end
    end

endmodule

[sv/sfc_div.sv]
`timescale 1ns / 1ps

module sfc_div
(
    input  logic                             clk,
    input  logic                             en,
    input  sfc_pkg::clip_t                   c,
    input  sfc_pkg::clip_t                   w,
    output logic signed [sfc_pkg::NDC_W-1:0] ndc
);
    import sfc_pkg::*;

    localparam logic [NDC_W-1:0] NDC_MAX = {1'b0, {(NDC_W-1){1'b1}}};
    localparam logic [NDC_W-1:0] NDC_MIN = {1'b1, {(NDC_W-1){1'b0}}};

    logic [REM_W-1:0]     num_a_reg;
    logic [CLIP_W-1:0]    dv_a_reg;
    logic                 neg_a_reg;
    logic [CLIP_W-1:0]    mag_c;
    logic [CLIP_W-1:0]    mag_w;

    logic [REM_W-1:0]     rem_reg [DIV_STEPS+1];
    logic [DIV_STEPS-1:0] q_reg   [DIV_STEPS+1];
    logic [CLIP_W-1:0]    dv_reg  [DIV_STEPS+1];
    logic                 neg_reg [DIV_STEPS+1];
    logic                 ov_reg  [DIV_STEPS+1];

    logic [NDC_W-1:0]     ndc_reg;
    logic [NDC_W-1:0]     ndc_next;
    logic [DIV_STEPS-1:0] qmag;

    assign mag_c = c[CLIP_W-1] ? CLIP_W'(-c) : CLIP_W'(c);
    assign mag_w = w[CLIP_W-1] ? CLIP_W'(-w) : CLIP_W'(w);
    assign ndc   = $signed(ndc_reg);

    // magnitudes and quotient sign
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_a_reg <= REM_W'(mag_c) << NDC_FRAC;
            dv_a_reg  <= mag_w;
            neg_a_reg <= c[CLIP_W-1] ^ w[CLIP_W-1];
        end
    end

    // overflow check against the full quotient range
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ov_reg[0]  <= num_a_reg >= (REM_W'(dv_a_reg) << DIV_STEPS);
            rem_reg[0] <= num_a_reg;
            q_reg[0]   <= '0;
            dv_reg[0]  <= dv_a_reg;
            neg_reg[0] <= neg_a_reg;
        end
    end

    // one quotient bit per stage, msb first
    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_step
        localparam int K = DIV_STEPS - 1 - i;
        logic [REM_W-1:0] sh;
        logic             take;

        assign sh   = REM_W'(dv_reg[i]) << K;
        assign take = rem_reg[i] >= sh;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i+1] <= take ? (rem_reg[i] - sh) : rem_reg[i];
                q_reg[i+1]   <= {q_reg[i][DIV_STEPS-2:0], take};
                dv_reg[i+1]  <= dv_reg[i];
                neg_reg[i+1] <= neg_reg[i];
                ov_reg[i+1]  <= ov_reg[i];
            end
        end
    end

    // sign and saturation
    assign qmag = q_reg[DIV_STEPS];

    always_comb
    begin
        if (!neg_reg[DIV_STEPS])
        begin
            if (ov_reg[DIV_STEPS] || qmag[DIV_STEPS-1])
            begin
                ndc_next = NDC_MAX;
            end
            else
            begin
                ndc_next = qmag;
            end
        end
        else
        begin
            if (ov_reg[DIV_STEPS] || (qmag[DIV_STEPS-1] && (|qmag[DIV_STEPS-2:0])))
            begin
                ndc_next = NDC_MIN;
            end
            else
            begin
                ndc_next = -qmag;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ndc_reg <= ndc_next;
        end
    end

endmodule

[sv/sfc_back.sv]
`timescale 1ns / 1ps

module sfc_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  sfc_pkg::item_t q_data,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_ready,
    output logic           in_view,
    output logic           degenerate
);
    import sfc_pkg::*;

    localparam logic signed [TEST_W-1:0] ONE_P = TEST_W'(NDC_ONE);
    localparam logic signed [TEST_W-1:0] ONE_N = -TEST_W'(NDC_ONE);

    // values that ride along the root stages
    typedef struct packed {
        logic                    valid;
        logic                    wz;
        logic signed [NDC_W-1:0] cx;
        logic signed [NDC_W-1:0] cy;
        logic signed [NDC_W-1:0] cz;
        logic [NDC_W-1:0]        dz;
    } side_t;

    logic                    en;
    logic signed [NDC_W-1:0] ndc [NUM_PTS][NUM_AXES];
    logic                    vd_reg  [DIV_LAT];
    logic                    wzd_reg [DIV_LAT];

    logic [NDC_W-1:0]        ad_reg  [NUM_AXES];
    logic signed [NDC_W-1:0] cen_reg [NUM_AXES];
    logic                    v_df_reg;
    logic                    wz_df_reg;

    logic [SQ_W-1:0]         sqx_reg;
    logic [SQ_W-1:0]         sqy_reg;
    side_t                   sq_side_reg;

    logic [SRT_W-1:0]        srem_reg [ROOT_W+1];
    logic [ROOT_W-1:0]       root_reg [ROOT_W+1];
    side_t                   side_reg [ROOT_W+1];

    logic                    out_valid_reg;
    logic                    in_view_reg;
    logic                    degenerate_reg;

    logic signed [TEST_W-1:0] r_ext;
    logic signed [TEST_W-1:0] d_ext;
    logic signed [TEST_W-1:0] cx_ext;
    logic signed [TEST_W-1:0] cy_ext;
    logic signed [TEST_W-1:0] cz_ext;
    logic                     culled;
    side_t                    fin;

    assign en         = !out_valid_reg || out_ready;
    assign pop        = q_valid && en;
    assign out_valid  = out_valid_reg;
    assign in_view    = in_view_reg;
    assign degenerate = degenerate_reg;

    // six perspective divides
    for (genvar p = 0; p < NUM_PTS; p++)
    begin : g_pt
        for (genvar a = 0; a < NUM_AXES; a++)
        begin : g_ax
            sfc_div u_div
            (
                .clk (clk),
                .en  (en),
                .c   (q_data.clip[p][a]),
                .w   (q_data.clip[p][3]),
                .ndc (ndc[p][a])
            );
        end
    end

    // control that tracks the divides
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV_LAT; i++)
            begin
                vd_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            vd_reg[0] <= pop;
            for (int i = 1; i < DIV_LAT; i++)
            begin
                vd_reg[i] <= vd_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wzd_reg[0] <= q_data.wz;
            for (int i = 1; i < DIV_LAT; i++)
            begin
                wzd_reg[i] <= wzd_reg[i-1];
            end
        end
    end

    // rim minus centre, absolute values
    always_ff @(posedge clk)
    begin
        logic signed [NDC_W:0] d;
        if (en)
        begin
            for (int a = 0; a < NUM_AXES; a++)
            begin
                d = (NDC_W+1)'(ndc[1][a]) - (NDC_W+1)'(ndc[0][a]);
                ad_reg[a]  <= d[NDC_W] ? NDC_W'(-d) : NDC_W'(d);
                cen_reg[a] <= ndc[0][a];
            end
            wz_df_reg <= wzd_reg[DIV_LAT-1];
        end
    end

    // squares of the xy differences
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqx_reg <= SQ_W'(ad_reg[0]) * SQ_W'(ad_reg[0]);
            sqy_reg <= SQ_W'(ad_reg[1]) * SQ_W'(ad_reg[1]);
        end
    end

    // valid for the difference stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_df_reg <= 1'b0;
        end
        else if (en)
        begin
            v_df_reg <= vd_reg[DIV_LAT-1];
        end
    end

    // values that travel with the squares
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_side_reg <= '0;
        end
        else if (en)
        begin
            sq_side_reg.valid <= v_df_reg;
            sq_side_reg.wz    <= wz_df_reg;
            sq_side_reg.cx    <= cen_reg[0];
            sq_side_reg.cy    <= cen_reg[1];
            sq_side_reg.cz    <= cen_reg[2];
            sq_side_reg.dz    <= ad_reg[2];
        end
    end

    // squared radius, start of the root
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            srem_reg[0] <= SRT_W'(sqx_reg) + SRT_W'(sqy_reg);
            root_reg[0] <= '0;
        end
    end

    // side values along the root stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= ROOT_W; i++)
            begin
                side_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            side_reg[0] <= sq_side_reg;
            for (int i = 1; i <= ROOT_W; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // integer square root, one result bit per stage
    for (genvar i = 0; i < ROOT_W; i++)
    begin : g_root
        localparam int K = ROOT_W - 1 - i;
        logic [SRT_W-1:0] t;
        logic             take;

        assign t    = (SRT_W'(root_reg[i]) << (K + 1)) | (SRT_W'(1) << (2 * K));
        assign take = srem_reg[i] >= t;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                srem_reg[i+1] <= take ? (srem_reg[i] - t) : srem_reg[i];
                root_reg[i+1] <= take ? (root_reg[i] | (ROOT_W'(1) << K)) : root_reg[i];
            end
        end
    end

    // plane tests
    assign fin    = side_reg[ROOT_W];
    assign r_ext  = $signed({{(TEST_W-ROOT_W){1'b0}}, root_reg[ROOT_W]});
    assign d_ext  = $signed({{(TEST_W-NDC_W){1'b0}}, fin.dz});
    assign cx_ext = TEST_W'(fin.cx);
    assign cy_ext = TEST_W'(fin.cy);
    assign cz_ext = TEST_W'(fin.cz);

    assign culled = (cx_ext - r_ext > ONE_P) || (cx_ext + r_ext < ONE_N)
                 || (cy_ext - r_ext > ONE_P) || (cy_ext + r_ext < ONE_N)
                 || (cz_ext - d_ext > ONE_P) || (cz_ext + d_ext < ONE_N);

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= fin.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in_view_reg    <= !fin.wz && !culled;
            degenerate_reg <= fin.wz;
        end
    end

endmodule

[sv/sphere_frustum_cull_test.sv]
// throughput: one sphere per cycle unless stalled; front stages, queue and back pipeline all stream
// the back pipeline depth is set by the 31-step divide and the 32-step square root
// a stalled output holds the back pipeline; the 4-entry queue lets the front keep going until it is full
// reset: asynchronous, active low; clears all matrix coefficients to zero and empties
// the pipeline and queue; the block is ready as soon as reset is released
`timescale 1ns / 1ps

module sphere_frustum_cull_test
(
    input  logic                             clk,
    input  logic                             rst_n,
    // centre_x, centre_y, centre_z, rim_x, rim_y, rim_z
    input  logic [sfc_pkg::IN_W-1:0]         s_axis_tdata,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // in_view, degenerate, zero fill
    output logic [sfc_pkg::OUT_W-1:0]        m_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sfc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sfc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import sfc_pkg::*;

    logic  push;
    item_t push_data;
    logic  q_full;
    logic  q_valid;
    item_t q_data;
    logic  pop;
    logic  in_view;
    logic  degenerate;

    assign cfg_ready = 1'b1;

    // front: transform and classify
    sfc_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (s_axis_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    // queue between the two halves
    sfc_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .out_valid (q_valid),
        .out_data  (q_data)
    );

    // back: divide, radius, plane tests
    sfc_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_data     (q_data),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .in_view    (in_view),
        .degenerate (degenerate)
    );

    always_comb
    begin
        m_axis_tdata                 = '0;
        m_axis_tdata[OUT_IN_VIEW]    = in_view;
        m_axis_tdata[OUT_DEGENERATE] = degenerate;
    end

    a_degenerate_culled: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && degenerate) |-> !in_view)
        else $error("degenerate sphere reported in view");

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps

module tb;
    import sfc_pkg::*;

    localparam int LATENCY   = 72;
    localparam int WATCHDOG  = 20000;
    localparam int N_RANDOM  = 2000;
    localparam int HOLD_LEN  = 300;

    typedef struct packed {
        logic signed [31:0] rz;
        logic signed [31:0] ry;
        logic signed [31:0] rx;
        logic signed [31:0] cz;
        logic signed [31:0] cy;
        logic signed [31:0] cx;
    } sphere_t;

    typedef struct packed {
        logic degenerate;
        logic in_view;
    } verdict_t;

    logic                  clk;
    logic                  rst_n;
    logic [IN_W-1:0]       s_axis_tdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [OUT_W-1:0]      m_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    sphere_frustum_cull_test dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // predictor copy of the clip matrix, Q8.24 coefficients
    logic signed [63:0] clip_coef [4][4];

    sphere_t  sphere_queue [$];
    verdict_t verdict_queue [$];

    int  errors = 0;
    int  beats_in = 0;
    int  beats_out = 0;
    int  culled_seen = 0;
    int  degen_seen = 0;
    int  idle_count = 0;
    bit  calm;
    int  src_gap;
    int  sink_gap;
    int  hold_cycles;
    bit  hold_go = 1'b0;
    bit  hold_done;
    bit  s_sent = 1'b0;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic signed [63:0] floor_sh(input logic signed [63:0] v, input int s);
        return v >>> s;
    endfunction

    function automatic logic signed [63:0] clip_dot(input int row, input logic signed [63:0] x,
                                                    input logic signed [63:0] y,
                                                    input logic signed [63:0] z);
        return floor_sh(clip_coef[row][0] * x, 24) + floor_sh(clip_coef[row][1] * y, 24)
             + floor_sh(clip_coef[row][2] * z, 24) + floor_sh(clip_coef[row][3], 8);
    endfunction

    function automatic logic signed [63:0] ndc_of(input logic signed [63:0] c,
                                                  input logic signed [63:0] w);
        logic signed [63:0] q;
        q = (c * 64'sd65536) / w;
        if (q > 64'sd1073741823)
            return 64'sd1073741823;
        if (q < -64'sd1073741824)
            return -64'sd1073741824;
        return q;
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic bit past_plane(input logic signed [63:0] c, input logic signed [63:0] e);
        return (c - e > 64'sd65536) || (c + e < -64'sd65536);
    endfunction

    function automatic verdict_t cull_verdict(input sphere_t s);
        logic signed [63:0] p [2][3];
        logic signed [63:0] n [2][3];
        logic signed [63:0] w;
        logic signed [63:0] dx;
        logic signed [63:0] dy;
        logic signed [63:0] dz;
        logic signed [63:0] r;
        verdict_t v;
        p[0][0] = s.cx; p[0][1] = s.cy; p[0][2] = s.cz;
        p[1][0] = s.rx; p[1][1] = s.ry; p[1][2] = s.rz;
        v.degenerate = 1'b0;
        for (int i = 0; i < 2; i++)
        begin
            w = clip_dot(3, p[i][0], p[i][1], p[i][2]);
            if (w == 0)
            begin
                v.degenerate = 1'b1;
                for (int a = 0; a < 3; a++)
                    n[i][a] = 0;
            end
            else
                for (int a = 0; a < 3; a++)
                    n[i][a] = ndc_of(clip_dot(a, p[i][0], p[i][1], p[i][2]), w);
        end
        if (v.degenerate)
            v.in_view = 1'b0;
        else
        begin
            dx = n[1][0] - n[0][0];
            dy = n[1][1] - n[0][1];
            dz = n[1][2] - n[0][2];
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            if (dz < 0) dz = -dz;
            r = int_sqrt(dx * dx + dy * dy);
            v.in_view = !(past_plane(n[0][0], r) || past_plane(n[0][1], r)
                          || past_plane(n[0][2], dz));
        end
        return v;
    endfunction

    // register write on the config channel, mirrored into the predictor
    task automatic write_reg(input int idx, input logic [63:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx[CFG_IDX_W-1:0];
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx < NUM_CFG)
        begin
            clip_coef[idx/2][(idx%2)*2]     = $signed(val[31:0]);
            clip_coef[idx/2][(idx%2)*2 + 1] = $signed(val[63:32]);
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_matrix(input logic [31:0] m [4][4]);
        for (int i = 0; i < NUM_CFG; i++)
            write_reg(i, {m[i/2][(i%2)*2 + 1], m[i/2][(i%2)*2]});
    endtask

    // wait until every expected verdict has arrived and the pipe drains
    task automatic drain;
        while (sphere_queue.size() != 0 || verdict_queue.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_coord(input int mode);
        case (mode)
            0: return $urandom;
            1: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
            default: return $urandom_range(0, 32'h0000_3FFF) - 32'h0000_2000;
        endcase
    endfunction

    function automatic sphere_t rand_sphere;
        sphere_t s;
        int mode;
        mode = $urandom_range(0, 9) == 0 ? 0 : ($urandom_range(0, 1) ? 1 : 2);
        s.cx = rand_coord(mode);
        s.cy = rand_coord(mode);
        s.cz = rand_coord(mode);
        if ($urandom_range(0, 3) == 0)
        begin
            s.rx = rand_coord(mode);
            s.ry = rand_coord(mode);
            s.rz = rand_coord(mode);
        end
        else
        begin
            s.rx = s.cx + $urandom_range(0, 32'h0003_0000) - 32'h0001_8000;
            s.ry = s.cy + $urandom_range(0, 32'h0003_0000) - 32'h0001_8000;
            s.rz = s.cz + $urandom_range(0, 32'h0003_0000) - 32'h0001_8000;
        end
        return s;
    endfunction

    task automatic push_sphere(input sphere_t s);
        sphere_queue.push_back(s);
    endtask

    task automatic wait_sent;
        while (sphere_queue.size() != 0)
            @(posedge clk);
    endtask

    // stimulus
    initial
    begin
        logic [31:0] m [4][4];
        sphere_t s;
        calm = 1'b0;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                clip_coef[r][c] = 0;
        cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset matrix: every w is zero, so all degenerate
        push_sphere('0);
        push_sphere({6{32'h7FFF_FFFF}});
        wait_sent();
        drain();

        // out-of-range index must be ignored
        write_reg(NUM_CFG, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(15, 64'h0100_0000_0100_0000);

        // identity with w = 1, translation only in w
        m = '{'{32'h0100_0000, 0, 0, 0}, '{0, 32'h0100_0000, 0, 0},
              '{0, 0, 32'h0100_0000, 0}, '{0, 0, 0, 32'h0100_0000}};
        load_matrix(m);
        push_sphere('0);
        push_sphere({32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0002_0000});
        push_sphere({32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0, 32'h0001_8000});
        push_sphere({32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'hFFFE_0000});
        push_sphere({32'h0, 32'h0, 32'h0, 32'h0, 32'h0002_0000, 32'h0});
        push_sphere({32'h0, 32'h0, 32'h0, 32'hFFFD_0000, 32'h0, 32'h0});
        push_sphere({32'h0003_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0});
        push_sphere({32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0});
        push_sphere({32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                     32'h8000_0000, 32'h7FFF_FFFF});
        push_sphere({6{32'hFFFF_FFFF}});
        wait_sent();
        drain();

        // perspective-like: w taken from z, so z = 0 gives zero w; also negative w
        m = '{'{32'h0100_0000, 0, 0, 0}, '{0, 32'h0100_0000, 0, 0},
              '{0, 0, 32'h0080_0000, 32'h0100_0000}, '{0, 0, 32'h0100_0000, 0}};
        load_matrix(m);
        push_sphere({32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0});
        push_sphere({32'h0004_0000, 32'h0, 32'h0, 32'h0004_0000, 32'h0, 32'h0});
        push_sphere({32'hFFFC_0000, 32'h0, 32'h0, 32'hFFFC_0000, 32'h0, 32'h0});
        push_sphere({32'h0000_0001, 32'h7FFF_0000, 32'h0, 32'h0000_0001, 32'h0, 32'h0});
        push_sphere({32'h0004_0000, 32'h0001_0000, 32'h0, 32'h0004_0000, 32'h0, 32'h0010_0000});
        wait_sent();
        drain();

        // random phases over several matrices, extremes first
        for (int phase = 0; phase < 5; phase++)
        begin
            for (int r = 0; r < 4; r++)
                for (int c = 0; c < 4; c++)
                    case (phase)
                        0: m[r][c] = (c == r) ? 32'h7FFF_FFFF : 32'h8000_0000;
                        1: m[r][c] = $urandom;
                        default: m[r][c] = (c == r || (r == 3 && c == 2))
                            ? $urandom_range(0, 32'h0200_0000) - 32'h0080_0000
                            : $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
                    endcase
            load_matrix(m);
            if (phase == 4)
                calm = 1'b1;
            for (int k = 0; k < N_RANDOM / 5; k++)
            begin
                s = rand_sphere();
                push_sphere(s);
                if (phase == 2 && k == 20)
                    hold_go = 1'b1;
                while (sphere_queue.size() > 16)
                    @(posedge clk);
            end
            wait_sent();
            drain();
        end

        $display("covered %0d spheres, %0d verdicts: %0d culled, %0d degenerate",
                 beats_in, beats_out, culled_seen, degen_seen);
        $display("matrix settings: reset, identity, perspective, extremes, random");
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // sender: drives beats from the pending queue on the falling edge
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            src_gap       <= 0;
        end
        else if (!(s_axis_tvalid && !s_sent))
        begin
            if (src_gap > 0)
            begin
                src_gap       <= src_gap - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (sphere_queue.size() != 0)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= sphere_queue[0];
                if (!calm && $urandom_range(0, 19) == 0)
                    src_gap <= $urandom_range(1, 10);
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // input beat bookkeeping at the rising edge
    always @(posedge clk)
    begin
        s_sent <= rst_n && s_axis_tvalid && s_axis_tready;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            verdict_queue.push_back(cull_verdict(sphere_queue.pop_front()));
            beats_in <= beats_in + 1;
        end
    end

    // receiver ready with random stalls and one long hold-off
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            sink_gap      <= 0;
            hold_cycles   <= 0;
            hold_done     <= 1'b0;
        end
        else if (hold_go && !hold_done)
        begin
            m_axis_tready <= 1'b0;
            hold_cycles   <= HOLD_LEN;
            hold_done     <= 1'b1;
        end
        else if (hold_cycles > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_cycles   <= hold_cycles - 1;
        end
        else if (sink_gap > 0)
        begin
            m_axis_tready <= 1'b0;
            sink_gap      <= sink_gap - 1;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if (!calm && $urandom_range(0, 19) == 0)
                sink_gap <= $urandom_range(1, 10);
        end
    end

    // monitor: compare each output beat with the oldest expected verdict
    always @(posedge clk)
    begin
        verdict_t got;
        verdict_t want;
        int bad;
        bad = 0;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.in_view    = m_axis_tdata[OUT_IN_VIEW];
            got.degenerate = m_axis_tdata[OUT_DEGENERATE];
            beats_out <= beats_out + 1;
            if (!got.in_view)
                culled_seen <= culled_seen + 1;
            if (got.degenerate)
                degen_seen <= degen_seen + 1;
            if (verdict_queue.size() == 0)
            begin
                $display("%0t: unexpected output beat, actual %b", $time, got);
                bad = bad + 1;
            end
            else
            begin
                want = verdict_queue.pop_front();
                if (got.in_view !== want.in_view)
                begin
                    $display("%0t: in_view expected %b actual %b", $time, want.in_view,
                             got.in_view);
                    bad = bad + 1;
                end
                if (got.degenerate !== want.degenerate)
                begin
                    $display("%0t: degenerate expected %b actual %b", $time,
                             want.degenerate, got.degenerate);
                    bad = bad + 1;
                end
                if (m_axis_tdata[OUT_W-1:2] !== '0)
                begin
                    $display("%0t: fill bits expected 0 actual %b", $time,
                             m_axis_tdata[OUT_W-1:2]);
                    bad = bad + 1;
                end
            end
            if (bad != 0)
                errors <= errors + bad;
        end
    end

    // watchdog on cycles with no accepted beat anywhere
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= WATCHDOG)
        begin
            $display("timeout after %0d idle cycles", WATCHDOG);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

endmodule
